// ===== hdl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, register indexes, types and states of the moving-average
// duty unit.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int WINDOW    = 16;
  localparam int SAMPLE_W  = 8;
  localparam int GAIN_W    = 8;
  localparam int OFFSET_W  = 16;
  localparam int DUTY_W    = 12;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W     = $clog2(SAMPLE_W);
  localparam int ACC_W     = OFFSET_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_TDATA_W = ((SAMPLE_W + DUTY_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX    = 2'd3;

  localparam logic [GAIN_W-1:0]          RST_DUTY_GAIN   = 8'd28;
  localparam logic signed [OFFSET_W-1:0] RST_DUTY_OFFSET = -16'sd2592;
  localparam logic [DUTY_W-1:0]          RST_DUTY_MIN    = 12'd10;
  localparam logic [DUTY_W-1:0]          RST_DUTY_MAX    = 12'd1990;

  typedef struct packed {
    logic [GAIN_W-1:0]          duty_gain;
    logic signed [OFFSET_W-1:0] duty_offset;
    logic [DUTY_W-1:0]          duty_min;
    logic [DUTY_W-1:0]          duty_max;
  } mavg_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic              full;
  } mavg_job_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [DUTY_W-1:0]   duty;
    logic                window_full;
  } mavg_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } mavg_state_t;

endpackage

// ===== hdl/mavg_serial_unit.sv =====
// ----------------------------------------------------------------------------
// mavg_serial_unit
// Bit-serial divide of the window sum by the fill count, bit-serial
// gain multiply with offset, then saturation to the duty limits.
// ----------------------------------------------------------------------------
module mavg_serial_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  mavg_pkg::mavg_cfg_t cfg,
  input  logic                start,
  input  mavg_pkg::mavg_job_t job,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_ready,
  output mavg_pkg::mavg_res_t res
);
  import mavg_pkg::*;

  mavg_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r;
  logic [SUM_W-1:0]        rem_r;
  logic [SUM_W-1:0]        dvs_r;
  logic [SAMPLE_W-1:0]     quo_r;
  logic [FILL_W-1:0]       fill_r;
  logic                    full_r;
  logic [GAIN_W-1:0]       gsr_r;
  logic signed [ACC_W-1:0] mcand_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [DUTY_W-1:0]       duty_r;

  logic                    do_div;
  logic                    do_mul;
  logic                    do_sat;
  logic                    last_bit;
  logic                    fits;
  logic [SAMPLE_W-1:0]     quo_nxt;
  logic signed [ACC_W-1:0] sat_v;
  logic signed [ACC_W-1:0] max_s;
  logic signed [ACC_W-1:0] min_s;

  assign last_bit = (cnt_r == '0);
  assign fits     = (rem_r >= dvs_r);
  assign quo_nxt  = {quo_r[SAMPLE_W-2:0], fits};
  assign max_s    = ACC_W'($signed({1'b0, cfg.duty_max}));
  assign min_s    = ACC_W'($signed({1'b0, cfg.duty_min}));

  always_comb begin
    sat_v = acc_r;
    if (sat_v > max_s) begin
      sat_v = max_s;
    end
    if (sat_v < min_s) begin
      sat_v = min_s;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DIV;
      ST_DIV:  if (last_bit) state_nxt = ST_MUL;
      ST_MUL:  if (last_bit) state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ready     = 1'b0;
    res_valid = 1'b0;
    do_div    = 1'b0;
    do_mul    = 1'b0;
    do_sat    = 1'b0;
    case (state_r)
      ST_IDLE: ready     = 1'b1;
      ST_DIV:  do_div    = 1'b1;
      ST_MUL:  do_mul    = 1'b1;
      ST_SAT:  do_sat    = 1'b1;
      ST_DONE: res_valid = 1'b1;
      default: ready     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((ready && start) || ((do_div || do_mul) && last_bit)) begin
        cnt_r <= CNT_W'(SAMPLE_W - 1);
      end else if (do_div || do_mul) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && start) begin
      rem_r  <= job.sum;
      dvs_r  <= SUM_W'(job.fill) << (SAMPLE_W - 1);
      quo_r  <= '0;
      fill_r <= job.fill;
      full_r <= job.full;
    end
    if (do_div) begin
      if (fits) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      quo_r <= quo_nxt;
      if (last_bit) begin
        mcand_r <= ACC_W'($signed({1'b0, quo_nxt}));
        acc_r   <= ACC_W'(cfg.duty_offset);
        gsr_r   <= cfg.duty_gain;
      end
    end
    if (do_mul) begin
      if (gsr_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      gsr_r   <= gsr_r >> 1;
      mcand_r <= mcand_r <<< 1;
    end
    if (do_sat) begin
      duty_r <= sat_v[DUTY_W-1:0];
    end
  end

  assign res.average     = quo_r;
  assign res.duty        = duty_r;
  assign res.window_full = full_r;

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    start && ready |=> state_r == ST_DIV)
    else $error("start not followed by divide");

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    do_div && last_bit |=> rem_r < SUM_W'(fill_r))
    else $error("division remainder not below fill count");

  a_fill_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    ready && start |-> job.fill != '0)
    else $error("zero divisor");

  a_duty_in_limits : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (cfg.duty_min <= cfg.duty_max) |->
      (res.duty >= cfg.duty_min) && (res.duty <= cfg.duty_max))
    else $error("duty outside limits");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

endmodule

// ===== hdl/moving_average_to_pwm_duty_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_to_pwm_duty_unit
// Moving average over the last 16 samples mapped to a saturated PWM duty.
// ----------------------------------------------------------------------------
// Each sample beat updates a 16-entry window and its running sum in the
// accept cycle, then the mean is found by a bit-serial divider (one quotient
// bit per cycle) and scaled by a bit-serial shift-add multiplier (one gain
// bit per cycle), followed by a saturation step and a step to hand over the
// result; no new sample is taken until the previous one has been handed
// over. A finished result waits in an output register, so the next sample
// is taken while the previous result is still stalled. While the window
// fills the mean is the sum over the fill count; duty is offset plus gain
// times mean, clamped to max first and then to min, so min wins when the
// limits cross.
module moving_average_to_pwm_duty_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mavg_pkg::SAMPLE_W-1:0]        in_tdata,   // sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mavg_pkg::OUT_TDATA_W-1:0]     out_tdata,  // average, duty, zero pad
  output logic                                 out_tuser,  // window_full
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mavg_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import mavg_pkg::*;

  mavg_cfg_t            cfg_r;
  logic [SAMPLE_W-1:0]  win_r [WINDOW];
  logic [SLOT_W-1:0]    slot_r;
  logic [FILL_W-1:0]    fill_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 out_tvalid_r;
  mavg_res_t            out_res_r;

  logic                 in_beat;
  logic                 full_now;
  logic [SAMPLE_W-1:0]  evict;
  mavg_job_t            job;
  logic                 unit_ready;
  logic                 res_valid;
  logic                 res_ready;
  mavg_res_t            res;

  assign cfg_ready = 1'b1;
  assign in_tready = unit_ready;
  assign in_beat   = in_tvalid && in_tready;
  assign full_now  = (fill_r == FILL_W'(WINDOW));
  assign evict     = full_now ? win_r[slot_r] : '0;

  assign job.sum  = sum_r - SUM_W'(evict) + SUM_W'(in_tdata);
  assign job.fill = full_now ? fill_r : fill_r + 1'b1;
  assign job.full = (job.fill == FILL_W'(WINDOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_gain   <= RST_DUTY_GAIN;
      cfg_r.duty_offset <= RST_DUTY_OFFSET;
      cfg_r.duty_min    <= RST_DUTY_MIN;
      cfg_r.duty_max    <= RST_DUTY_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DUTY_GAIN:   cfg_r.duty_gain   <= cfg_data[GAIN_W-1:0];
        REG_DUTY_OFFSET: cfg_r.duty_offset <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_DUTY_MIN:    cfg_r.duty_min    <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MAX:    cfg_r.duty_max    <= cfg_data[DUTY_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (in_beat) begin
      slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      fill_r <= job.fill;
      sum_r  <= job.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      win_r[slot_r] <= in_tdata;
    end
  end

  mavg_serial_unit u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid),
    .job       (job),
    .ready     (unit_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.duty, out_res_r.average});
  assign out_tuser  = out_res_r.window_full;

endmodule
